[hdl/awm_pkg.sv]
package awm_pkg;

   localparam int OPCODE_W = 2;
   localparam int LETTER_W = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } opcode_type;

   // Per-request command to the letter histograms.
   typedef struct packed {
      logic                clear_all;
      logic                restart;
      logic                pat_inc;
      logic                txt_inc;
      logic                txt_dec;
      logic [LETTER_W-1:0] letter;
      logic [LETTER_W-1:0] old_letter;
   } hist_cmd_type;

   typedef struct packed {
      logic pattern_overflow;
      logic found;
      logic match_here;
   } result_type;

endpackage

[hdl/awm_ring.sv]
module awm_ring #(
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [awm_pkg::LETTER_W-1:0]               wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [awm_pkg::LETTER_W-1:0]               rd_data
);

   logic [awm_pkg::LETTER_W-1:0] ring_ff [DEPTH];
   logic [awm_pkg::LETTER_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   // Write-first read: a letter written this cycle at the address read next is forwarded.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/awm_hist.sv]
module awm_hist #(
   parameter int ALPHABET    = 26,
   parameter int MAX_PATTERN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  awm_pkg::hist_cmd_type cmd,
   output logic                  all_equal_in
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);

   logic [CNT_W-1:0] pat_ff [ALPHABET];
   logic [CNT_W-1:0] pat_in [ALPHABET];
   logic [CNT_W-1:0] win_ff [ALPHABET];
   logic [CNT_W-1:0] win_in [ALPHABET];
   logic [ALPHABET-1:0] equal;

   // Each letter cell updates its own pair of counts; the window matches the
   // pattern exactly when every cell agrees.
   always_comb begin
      for (int i = 0; i < ALPHABET; i++) begin
         logic hit_new;
         logic hit_old;
         hit_new = (32'(cmd.letter) == i);
         hit_old = (32'(cmd.old_letter) == i);
         if (cmd.clear_all) begin
            pat_in[i] = '0;
         end else if (cmd.pat_inc && hit_new) begin
            pat_in[i] = pat_ff[i] + CNT_W'(1);
         end else begin
            pat_in[i] = pat_ff[i];
         end
         if (cmd.clear_all || cmd.restart) begin
            win_in[i] = '0;
         end else if ((cmd.txt_inc && hit_new) && !(cmd.txt_dec && hit_old)) begin
            win_in[i] = win_ff[i] + CNT_W'(1);
         end else if ((cmd.txt_dec && hit_old) && !(cmd.txt_inc && hit_new)) begin
            win_in[i] = win_ff[i] - CNT_W'(1);
         end else begin
            win_in[i] = win_ff[i];
         end
         equal[i] = (pat_in[i] == win_in[i]);
      end
   end

   assign all_equal_in = &equal;

   always_ff @(posedge clock) begin
      for (int i = 0; i < ALPHABET; i++) begin
         if (reset) begin
            pat_ff[i] <= '0;
            win_ff[i] <= '0;
         end else begin
            pat_ff[i] <= pat_in[i];
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

[hdl/awm_out_buf.sv]
module awm_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  awm_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output awm_pkg::result_type out_data
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   awm_pkg::result_type main_data_ff, main_data_in;
   awm_pkg::result_type skid_data_ff, skid_data_in;
   logic                push;
   logic                pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

[hdl/anagram_window_matcher.sv]
// An accepted request's result goes straight into the output buffer's main
// register when the result side is free; a two-entry buffer absorbs stalls.
// Throughput: one request per cycle unless the buffer is full; histograms,
// ring and counters update on acceptance and issue the next letter's ring read.
// Reset (synchronous, active high) empties the output buffer and clears both
// histograms, pointer, lengths and flags; the history ring is not cleared.
module anagram_window_matcher #(
   parameter int MAX_PATTERN = 64,
   parameter int ALPHABET    = 26
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [1:0] opcode, [6:2] letter, [7] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] match_here, [1] found, [2] pattern_overflow
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [awm_pkg::OPCODE_W-1:0] opcode;
   logic [awm_pkg::LETTER_W-1:0] letter;
   logic                         accept;
   logic                         in_range;
   logic                         do_clear;
   logic                         pat_any;
   logic                         pat_full;
   logic                         pat_take;
   logic                         txt_take;
   logic                         win_full;
   logic                         all_equal_in;
   logic                         match;
   logic [LEN_W-1:0]             fill_after;
   logic [LEN_W-1:0]             ptr_plus;
   logic [awm_pkg::LETTER_W-1:0] old_letter;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             found_ff, found_in;
   logic             overflow_ff, overflow_in;

   awm_pkg::hist_cmd_type hist_cmd;
   awm_pkg::result_type   result;
   awm_pkg::result_type   rsp_result;

   assign opcode = req_tdata[1:0];
   assign letter = req_tdata[6:2];
   assign accept = req_tvalid && req_tready;

   assign in_range = (32'(letter) < ALPHABET);
   assign do_clear = accept && (opcode == awm_pkg::OP_CLEAR);
   assign pat_any  = accept && (opcode == awm_pkg::OP_PATTERN) && in_range;
   assign pat_full = (len_ff == LEN_W'(MAX_PATTERN));
   assign pat_take = pat_any && !pat_full;
   assign txt_take = accept && (opcode == awm_pkg::OP_TEXT) && in_range && (len_ff != '0);
   assign win_full = (fill_ff == len_ff);

   assign fill_after = win_full ? fill_ff : fill_ff + LEN_W'(1);
   assign ptr_plus   = LEN_W'(ptr_ff) + LEN_W'(1);

   always_comb begin
      len_in      = len_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      found_in    = found_ff;
      overflow_in = overflow_ff;
      if (do_clear) begin
         len_in      = '0;
         fill_in     = '0;
         ptr_in      = '0;
         found_in    = 1'b0;
         overflow_in = 1'b0;
      end else if (pat_take) begin
         len_in   = len_ff + LEN_W'(1);
         fill_in  = '0;
         ptr_in   = '0;
         found_in = 1'b0;
      end else if (pat_any) begin
         overflow_in = 1'b1;
      end else if (txt_take) begin
         fill_in = fill_after;
         ptr_in  = (ptr_plus >= len_ff) ? '0 : ptr_plus[PTR_W-1:0];
         if (match) begin
            found_in = 1'b1;
         end
      end
   end

   always_comb begin
      hist_cmd.clear_all  = do_clear;
      hist_cmd.restart    = pat_take;
      hist_cmd.pat_inc    = pat_take;
      hist_cmd.txt_inc    = txt_take;
      // The oldest letter leaves only once the window already spans the pattern.
      hist_cmd.txt_dec    = txt_take && win_full;
      hist_cmd.letter     = letter;
      hist_cmd.old_letter = old_letter;
   end

   assign match = txt_take && (fill_after == len_ff) && all_equal_in;

   awm_hist #(
      .ALPHABET    (ALPHABET),
      .MAX_PATTERN (MAX_PATTERN)
   ) u_hist (
      .clock        (clock),
      .reset        (reset),
      .cmd          (hist_cmd),
      .all_equal_in (all_equal_in)
   );

   // The ring is read at the pointer of the next request, so the leaving letter
   // is ready in a register when that request arrives.
   awm_ring #(
      .DEPTH (MAX_PATTERN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (txt_take),
      .wr_addr (ptr_ff),
      .wr_data (letter),
      .rd_addr (ptr_in),
      .rd_data (old_letter)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         fill_ff     <= '0;
         ptr_ff      <= '0;
         found_ff    <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         len_ff      <= len_in;
         fill_ff     <= fill_in;
         ptr_ff      <= ptr_in;
         found_ff    <= found_in;
         overflow_ff <= overflow_in;
      end
   end

   always_comb begin
      result.match_here       = match;
      result.found            = found_in;
      result.pattern_overflow = overflow_in;
   end

   awm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {5'b0, rsp_result};

endmodule

[hdl/awm_checker.sv]
module awm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // The request side closes only when results are waiting.
   a_full_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side blocked with no result waiting");

   // A clear request into an empty buffer shows an all-zero result next cycle.
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && (req_tdata[1:0] == awm_pkg::OP_CLEAR)
      |=> rsp_tvalid && (rsp_tdata[2:0] == 3'b000))
      else $error("clear request gave a nonzero result");

endmodule

bind anagram_window_matcher awm_checker u_awm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_PATTERN_LEN = 64;
   localparam int ALPHABET_SIZE   = 26;
   localparam int CYCLE_LIMIT     = 200000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [1:0] opcode, [6:2] letter, [7] zero
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [0] match_here, [1] found, [2] pattern_overflow

   anagram_window_matcher DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted state of the matcher.
   logic [6:0] pat_hist [ALPHABET_SIZE];
   logic [6:0] win_hist [ALPHABET_SIZE];
   logic [4:0] history [MAX_PATTERN_LEN];
   logic [5:0] ring_ptr;
   logic [6:0] pat_len;
   logic [6:0] win_fill;
   logic [4:0] diff_count;
   logic       found_sticky;
   logic       overflow_sticky;

   awm_pkg::result_type pending_results[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int requests_accepted  = 0;
   int results_checked    = 0;
   int matches_seen       = 0;
   int overflows_seen     = 0;
   int error_count        = 0;
   int cycle_count        = 0;

   always #6 clock = ~clock;

   function automatic void clear_model();
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         pat_hist[i] = '0;
         win_hist[i] = '0;
      end
      ring_ptr        = '0;
      pat_len         = '0;
      win_fill        = '0;
      diff_count      = '0;
      found_sticky    = 1'b0;
      overflow_sticky = 1'b0;
   endfunction

   // Moves one window count up or down and keeps the number of letters whose
   // window and pattern counts disagree exact.
   function automatic void adjust_window(input int ch, input bit up);
      bit agreed_before;
      bit agreed_after;
      agreed_before = (win_hist[ch] == pat_hist[ch]);
      if (up)
         win_hist[ch] = win_hist[ch] + 1'b1;
      else if (win_hist[ch] != 0)
         win_hist[ch] = win_hist[ch] - 1'b1;
      agreed_after = (win_hist[ch] == pat_hist[ch]);
      if (agreed_before && !agreed_after)
         diff_count = diff_count + 1'b1;
      else if (!agreed_before && agreed_after && diff_count != 0)
         diff_count = diff_count - 1'b1;
   endfunction

   function automatic awm_pkg::result_type anagram_step(input logic [1:0] op,
                                                        input logic [4:0] letter);
      awm_pkg::result_type res;
      int slot;
      res = '0;
      if (op == awm_pkg::OP_CLEAR) begin
         clear_model();
      end else if (op == awm_pkg::OP_PATTERN && letter < ALPHABET_SIZE) begin
         if (pat_len >= MAX_PATTERN_LEN) begin
            overflow_sticky = 1'b1;
         end else begin
            pat_hist[letter] = pat_hist[letter] + 1'b1;
            pat_len          = pat_len + 1'b1;
            found_sticky     = 1'b0;
            ring_ptr         = '0;
            win_fill         = '0;
            diff_count       = '0;
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
               win_hist[i] = '0;
               if (pat_hist[i] != 0) diff_count = diff_count + 1'b1;
            end
         end
      end else if (op == awm_pkg::OP_TEXT && letter < ALPHABET_SIZE && pat_len != 0) begin
         slot = ring_ptr;
         // The oldest letter leaves only once the window is full.
         if (win_fill >= pat_len) adjust_window(history[slot], 1'b0);
         history[slot] = letter;
         adjust_window(letter, 1'b1);
         ring_ptr = (slot + 1 >= pat_len) ? '0 : 6'(slot + 1);
         if (win_fill < pat_len) win_fill = win_fill + 1'b1;
         if (win_fill == pat_len && diff_count == 0) begin
            res.match_here = 1'b1;
            found_sticky   = 1'b1;
         end
      end
      res.found            = found_sticky;
      res.pattern_overflow = overflow_sticky;
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic expected,
                                         input logic actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, expected, actual);
         error_count++;
      end
   endfunction

   // Result checking comes before prediction, so a response can never be matched
   // against the request accepted at the same edge.
   always @(posedge clock) begin
      awm_pkg::result_type expected;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               expected = pending_results.pop_front();
               compare_field("match_here", expected.match_here, rsp_tdata[0]);
               compare_field("found", expected.found, rsp_tdata[1]);
               compare_field("pattern_overflow", expected.pattern_overflow, rsp_tdata[2]);
               results_checked++;
               if (rsp_tdata[0]) matches_seen++;
               if (rsp_tdata[2]) overflows_seen++;
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.insert(pending_results.size(),
                                   anagram_step(req_tdata[1:0], req_tdata[6:2]));
            requests_accepted++;
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [4:0] letter);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, letter, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Holds the sender off until every outstanding result has been returned.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(awm_pkg::OP_CLEAR, 5'd0);
      send_request(awm_pkg::OP_TEXT, 5'd0);          // no pattern yet
      send_request(awm_pkg::OP_PATTERN, 5'd0);
      send_request(awm_pkg::OP_PATTERN, 5'd25);
      send_request(awm_pkg::OP_TEXT, 5'd25);
      send_request(awm_pkg::OP_TEXT, 5'd0);
      send_request(awm_pkg::OP_TEXT, 5'd0);
      send_request(awm_pkg::OP_TEXT, 5'd25);
      send_request(awm_pkg::OP_PATTERN, 5'd31);      // letters past z are ignored
      send_request(awm_pkg::OP_TEXT, 5'd26);
      send_request(awm_pkg::OP_TEXT, 5'd31);
      send_request(OP_UNUSED, 5'd0);
      send_request(OP_UNUSED, 5'd31);
      send_request(awm_pkg::OP_TEXT, 5'd0);
      send_request(awm_pkg::OP_PATTERN, 5'd1);       // restarts the window, clears found
      send_request(awm_pkg::OP_TEXT, 5'd1);
      send_request(awm_pkg::OP_TEXT, 5'd0);
      send_request(awm_pkg::OP_TEXT, 5'd25);
      send_request(awm_pkg::OP_CLEAR, 5'd31);
      send_request(awm_pkg::OP_PATTERN, 5'd16);
      send_request(awm_pkg::OP_TEXT, 5'd16);
      send_request(awm_pkg::OP_TEXT, 5'd15);
      send_request(awm_pkg::OP_TEXT, 5'd16);
      send_request(awm_pkg::OP_CLEAR, 5'd0);
      wait_for_drain();
   endtask

   // Fills the pattern to capacity, overruns it, then streams a periodic text so
   // the ring wraps and full-length windows match once per period.
   task automatic test_pattern_overflow();
      send_request(awm_pkg::OP_CLEAR, 5'd0);
      for (int i = 0; i < MAX_PATTERN_LEN + 2; i++)
         send_request(awm_pkg::OP_PATTERN, 5'(i % 3));
      for (int i = 0; i < MAX_PATTERN_LEN + 12; i++)
         send_request(awm_pkg::OP_TEXT, 5'(i % 3));
      send_request(awm_pkg::OP_PATTERN, 5'd4);
      send_request(awm_pkg::OP_CLEAR, 5'd0);
      wait_for_drain();
   endtask

   // Random sessions: an optional clear, a pattern (usually short) over a narrow letter
   // range, then text mostly from that range so permutations occur often.
   task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
      int sent;
      int base;
      int span;
      int plen;
      int tlen;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 60) begin
            send_request(awm_pkg::OP_CLEAR, 5'($urandom_range(0, 31)));
            sent++;
         end
         span = $urandom_range(1, 4);
         base = $urandom_range(0, ALPHABET_SIZE - span);
         if ($urandom_range(99) < 5) begin
            plen = $urandom_range(20, MAX_PATTERN_LEN + 6);
            tlen = $urandom_range(plen, plen + 40);
         end else begin
            plen = $urandom_range(1, 6);
            tlen = $urandom_range(plen, 3 * plen + 8);
         end
         repeat (plen) begin
            send_request(awm_pkg::OP_PATTERN, 5'(base + $urandom_range(0, span - 1)));
            sent++;
         end
         repeat (tlen) begin
            if ($urandom_range(99) < 8) begin
               send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
            end else begin
               if ($urandom_range(99) < 85)
                  send_request(awm_pkg::OP_TEXT, 5'(base + $urandom_range(0, span - 1)));
               else
                  send_request(awm_pkg::OP_TEXT, 5'($urandom_range(0, ALPHABET_SIZE - 1)));
               sent++;
            end
         end
      end
      wait_for_drain();
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      clear_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_pattern_overflow();
      test_random_traffic(80, 0, 0);
      test_random_traffic(80, 82, 0);
      test_random_traffic(80, 0, 82);
      test_random_traffic(80, 21, 21);

      repeat (8) @(posedge clock);
      $display("Run covered %0d requests and %0d checked results, %0d window matches,",
               requests_accepted, results_checked, matches_seen);
      $display("%0d results with pattern overflow, across four idle and stall phases.",
               overflows_seen);
      if (error_count == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
hdl/awm_pkg.sv
hdl/awm_ring.sv
hdl/awm_hist.sv
hdl/awm_out_buf.sv
hdl/anagram_window_matcher.sv
hdl/awm_checker.sv
verif/testbench.sv
